@@ rtl/assert_macros.svh @@
// Assertion helpers for the bound checker ps2q_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/ps2q_pkg.sv @@
`default_nettype none

package ps2q_pkg;

    localparam int QUEUE_SIZE_DEF = 16;
    localparam int TICKS_W        = 20;
    localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 20'd100000;

    localparam int ERR_FRAMING_BIT = 0;
    localparam int ERR_PARITY_BIT  = 1;
    localparam int ERR_OVERRUN_BIT = 2;
    localparam int ERR_TIMEOUT_BIT = 3;

    typedef enum logic [2:0] {
        MODE_RX       = 3'd0,
        MODE_TX_DONE  = 3'd1,
        MODE_POP      = 3'd2,
        MODE_READ_ERR = 3'd3,
        MODE_SEND     = 3'd4,
        MODE_TICK     = 3'd5
    } t_mode;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_byte;
        logic       parity_bit;
        logic       frame_error;
        logic       tx_nack;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       read_valid;
        logic       rx_avail;
        logic [3:0] error_flags;
        logic [7:0] error_byte;
        logic       tx_busy;
        logic       tx_nack_seen;
        logic       tx_parity;
        logic       send_accepted;
    } t_out_item;

endpackage

`default_nettype wire

@@ rtl/ps2q_ifs.sv @@
`default_nettype none

interface ps2q_in_if import ps2q_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
    modport mon    (input valid, input payload, input ready);
endinterface

interface ps2q_out_if import ps2q_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
    modport mon    (input valid, input payload, input ready);
endinterface

`default_nettype wire

@@ rtl/ps2q_ram.sv @@
`default_nettype none

module ps2q_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/ps2_rx_queue_tx_handshake.sv @@
// PS/2 host-side receive queue, error flags and transmit handshake.
// Request channel i_req carries one event (rx frame, tx done, pop, read and
// clear errors, send, tick) per accepted request; response channel o_rsp
// returns exactly one status item per request, in order.
// Good frames enter a ring queue of QUEUE_SIZE slots (QUEUE_SIZE-1 usable)
// held in a RAM with registered read; bad frames set sticky flags.
// The timeout register is written through i_cfg_we/i_cfg_wdata; the user
// must do so only while idle, as the block itself does not enforce it.
// An accepted request is registered in r_in and its status then in r_out.
// Throughput: one request per cycle while o_rsp does not stall, set by the
// single pass through the update logic and the one RAM read port.
// Reset (synchronous, i_rst_n low) empties the queue, clears all flags and
// the busy state, and loads the timeout register with 100000 ticks.
// When o_rsp stalls, the response register and RAM read data hold; one more
// request is buffered in the input register, then i_req.ready drops.
`default_nettype none

module ps2_rx_queue_tx_handshake import ps2q_pkg::*; #(
    parameter int QUEUE_SIZE = QUEUE_SIZE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [TICKS_W-1:0] i_cfg_wdata,
    ps2q_in_if.sink                 i_req,
    ps2q_out_if.source              o_rsp
);

    localparam int AW = $clog2(QUEUE_SIZE);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_SIZE - 1);

    t_in_item           r_in;
    logic               r_in_valid;
    t_out_item          r_out;
    t_out_item          n_out;
    logic               r_out_valid;
    logic [TICKS_W-1:0] r_timeout_ticks;
    logic [AW-1:0]      r_head, n_head;
    logic [AW-1:0]      r_tail, n_tail;
    logic [3:0]         r_errors, n_errors;
    logic [7:0]         r_bad_byte, n_bad_byte;
    logic               r_busy, n_busy;
    logic               r_nack, n_nack;
    logic [TICKS_W-1:0] r_left, n_left;
    logic [TICKS_W-1:0] left_dec;
    logic [AW-1:0]      tail_next;
    logic [AW-1:0]      head_next;
    logic               advance;
    logic               fire;
    logic               ram_we;
    logic               ram_re;
    logic [7:0]         ram_rdata;
    logic [3:0]         flags_rep;
    logic               reported;
    logic               rx_par_ok;

    assign advance       = !r_out_valid || o_rsp.ready;
    assign fire          = r_in_valid && advance;
    assign i_req.ready   = !r_in_valid || advance;
    assign tail_next     = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign head_next     = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign left_dec      = (r_left != '0) ? r_left - 1'b1 : r_left;
    assign rx_par_ok     = (r_in.parity_bit == ~^r_in.data_byte);

    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_errors   = r_errors;
        n_bad_byte = r_bad_byte;
        n_busy     = r_busy;
        n_nack     = r_nack;
        n_left     = r_left;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        flags_rep  = r_errors;
        reported   = 1'b0;
        n_out      = '0;

        case (r_in.mode)
            MODE_RX: begin
                if (r_in.frame_error) begin
                    n_bad_byte = r_in.data_byte;
                    n_errors[ERR_FRAMING_BIT] = 1'b1;
                end else if (!rx_par_ok) begin
                    n_bad_byte = r_in.data_byte;
                    n_errors[ERR_PARITY_BIT] = 1'b1;
                end else if (tail_next == r_head) begin
                    n_errors[ERR_OVERRUN_BIT] = 1'b1;
                end else begin
                    ram_we = 1'b1;
                    n_tail = tail_next;
                end
            end
            MODE_TX_DONE: begin
                n_nack = r_in.tx_nack;
                n_busy = 1'b0;
                n_left = '0;
            end
            MODE_POP: begin
                if (r_head != r_tail) begin
                    ram_re           = 1'b1;
                    n_out.read_valid = 1'b1;
                    n_head           = head_next;
                end
            end
            MODE_READ_ERR: begin
                reported = 1'b1;
                n_errors = '0;
            end
            MODE_SEND: begin
                n_out.tx_parity = ~^r_in.data_byte;
                if (!r_busy) begin
                    n_busy              = 1'b1;
                    n_out.send_accepted = 1'b1;
                    n_left = (r_timeout_ticks != '0) ? r_timeout_ticks : TICKS_W'(1);
                end
            end
            MODE_TICK: begin
                if (r_busy) begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_busy = 1'b0;
                        n_errors[ERR_TIMEOUT_BIT] = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        n_out.rx_avail      = (n_head != n_tail);
        n_out.error_flags   = reported ? flags_rep : n_errors;
        n_out.error_byte    = n_bad_byte;
        n_out.tx_busy       = n_busy;
        n_out.tx_nack_seen  = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_timeout_ticks <= TIMEOUT_RESET;
            r_head          <= '0;
            r_tail          <= '0;
            r_errors        <= '0;
            r_bad_byte      <= '0;
            r_busy          <= 1'b0;
            r_nack          <= 1'b0;
            r_left          <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout_ticks <= i_cfg_wdata;
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_head     <= n_head;
                r_tail     <= n_tail;
                r_errors   <= n_errors;
                r_bad_byte <= n_bad_byte;
                r_busy     <= n_busy;
                r_nack     <= n_nack;
                r_left     <= n_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in <= i_req.payload;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    ps2q_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (fire && ram_we),
        .i_waddr (r_tail),
        .i_wdata (r_in.data_byte),
        .i_re    (fire && ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // popped byte arrives from the RAM output register alongside r_out
    always_comb begin
        o_rsp.payload           = r_out;
        o_rsp.payload.read_byte = r_out.read_valid ? ram_rdata : 8'd0;
    end

    assign o_rsp.valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/ps2q_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module ps2q_checker import ps2q_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_req_ready,
    input wire logic      i_rsp_valid,
    input wire logic      i_rsp_ready,
    input wire t_out_item i_rsp
);

    logic other_shown;
    logic pop_shown;
    logic send_shown;
    logic rsp_held;

    assign other_shown = i_rsp_valid && !i_rsp.read_valid;
    assign pop_shown   = i_rsp_valid && i_rsp.read_valid;
    assign send_shown  = i_rsp_valid && i_rsp.send_accepted;
    assign rsp_held    = i_rsp_valid && !i_rsp_ready;

    `ASSERT_IMPL(a_byte_only_on_pop, i_clk, i_rst_n, other_shown, i_rsp.read_byte == 8'd0)
    `ASSERT_IMPL(a_send_sets_busy, i_clk, i_rst_n, send_shown, i_rsp.tx_busy)
    `ASSERT_IMPL(a_pop_not_send, i_clk, i_rst_n, pop_shown, !i_rsp.send_accepted && !i_rsp.tx_parity)
    `ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_held, i_rsp_valid && $stable(i_rsp))
    `ASSERT_IMPL(a_req_ready_on_drain, i_clk, i_rst_n, i_rsp_ready, i_req_ready)

endmodule

bind ps2_rx_queue_tx_handshake ps2q_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);

`default_nettype wire

@@ test/ps2q_status_checker.sv @@
module ps2q_status_checker import ps2q_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TICKS_W-1:0] i_cfg_wdata,
    ps2q_in_if.mon             i_req,
    ps2q_out_if.mon            i_rsp,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_popped,
    output int                 o_overruns,
    output int                 o_expiries
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]         rx_bytes [QUEUE_SIZE_DEF];
    int                 rx_head;
    int                 rx_tail;
    logic [3:0]         err_sticky;
    logic [7:0]         bad_byte;
    logic               tx_pending;
    logic               tx_nacked;
    logic [TICKS_W-1:0] ticks_left;
    logic [TICKS_W-1:0] timeout_cfg;
    t_out_item          status_expected [$];
    int                 fails;
    int                 checked;
    int                 popped;
    int                 overruns;
    int                 expiries;

    function automatic int ring_step(input int idx);
        return (idx + 1 == QUEUE_SIZE_DEF) ? 0 : idx + 1;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t ns: MISMATCH %s: got %h expected %h", $time, what, got, want);
        fails++;
    endtask

    task automatic check_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch(what, {8'h00, got}, {8'h00, want});
        end
    endtask

    // Status that one request leaves behind, applied to the local copy of the state.
    task automatic predict_status(input t_in_item req, output t_out_item st);
        logic [3:0] flags_seen;
        logic       flags_read;
        int         nt;
        st = '0;
        flags_seen = '0;
        flags_read = 1'b0;
        case (req.mode)
            MODE_RX: begin
                if (req.frame_error) begin
                    bad_byte = req.data_byte;
                    err_sticky[ERR_FRAMING_BIT] = 1'b1;
                end else if (req.parity_bit != ~^req.data_byte) begin
                    bad_byte = req.data_byte;
                    err_sticky[ERR_PARITY_BIT] = 1'b1;
                end else begin
                    nt = ring_step(rx_tail);
                    if (nt == rx_head) begin
                        err_sticky[ERR_OVERRUN_BIT] = 1'b1;
                        overruns++;
                    end else begin
                        rx_bytes[rx_tail] = req.data_byte;
                        rx_tail = nt;
                    end
                end
            end
            MODE_TX_DONE: begin
                tx_nacked = req.tx_nack;
                tx_pending = 1'b0;
                ticks_left = '0;
            end
            MODE_POP: begin
                if (rx_head != rx_tail) begin
                    st.read_byte = rx_bytes[rx_head];
                    st.read_valid = 1'b1;
                    rx_head = ring_step(rx_head);
                    popped++;
                end
            end
            MODE_READ_ERR: begin
                flags_seen = err_sticky;
                flags_read = 1'b1;
                err_sticky = '0;
            end
            MODE_SEND: begin
                st.tx_parity = ~^req.data_byte;
                if (!tx_pending) begin
                    tx_pending = 1'b1;
                    st.send_accepted = 1'b1;
                    ticks_left = (timeout_cfg == '0) ? TICKS_W'(1) : timeout_cfg;
                end
            end
            MODE_TICK: begin
                if (tx_pending) begin
                    if (ticks_left != '0) begin
                        ticks_left = ticks_left - 1'b1;
                    end
                    if (ticks_left == '0) begin
                        tx_pending = 1'b0;
                        err_sticky[ERR_TIMEOUT_BIT] = 1'b1;
                        expiries++;
                    end
                end
            end
            default: begin
            end
        endcase
        st.rx_avail = (rx_head != rx_tail);
        st.error_flags = flags_read ? flags_seen : err_sticky;
        st.error_byte = bad_byte;
        st.tx_busy = tx_pending;
        st.tx_nack_seen = tx_nacked;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        t_out_item st;
        if (!i_rst_n) begin
            rx_head = 0;
            rx_tail = 0;
            err_sticky = '0;
            bad_byte = '0;
            tx_pending = 1'b0;
            tx_nacked = 1'b0;
            ticks_left = '0;
            timeout_cfg = TIMEOUT_RESET;
            status_expected.delete();
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.payload;
                if (status_expected.size() == 0) begin
                    report_mismatch("response with nothing outstanding", 16'(got), '0);
                end else begin
                    want = status_expected.pop_front();
                    check_field("read_byte", got.read_byte, want.read_byte);
                    check_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
                    check_field("rx_avail", 8'(got.rx_avail), 8'(want.rx_avail));
                    check_field("error_flags", 8'(got.error_flags), 8'(want.error_flags));
                    check_field("error_byte", got.error_byte, want.error_byte);
                    check_field("tx_busy", 8'(got.tx_busy), 8'(want.tx_busy));
                    check_field("tx_nack_seen", 8'(got.tx_nack_seen),
                                8'(want.tx_nack_seen));
                    check_field("tx_parity", 8'(got.tx_parity), 8'(want.tx_parity));
                    check_field("send_accepted", 8'(got.send_accepted),
                                8'(want.send_accepted));
                    checked++;
                end
            end
            if (i_cfg_we) begin
                timeout_cfg = i_cfg_wdata;
            end
            if (i_req.valid && i_req.ready) begin
                predict_status(i_req.payload, st);
                status_expected.push_back(st);
            end
        end
        o_pending <= status_expected.size();
        o_fail_count <= fails;
        o_checked <= checked;
        o_popped <= popped;
        o_overruns <= overruns;
        o_expiries <= expiries;
    end

endmodule

@@ test/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2q_pkg::*;

    localparam logic [2:0] MODE_NOP_A = 3'd6;
    localparam logic [2:0] MODE_NOP_B = 3'd7;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 170;
    localparam int NUM_PHASES    = 6;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;

    typedef enum int {MIX_TRAFFIC, FILL_QUEUE, DRAIN_QUEUE, TX_TRAFFIC} t_bias;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [TICKS_W-1:0] cfg_wdata;
    logic               no_idle;
    logic               hold_rsp;
    logic               hold_served;
    int                 requests_issued;
    int                 fail_count;
    int                 pending;
    int                 checked;
    int                 popped;
    int                 overruns;
    int                 expiries;

    ps2q_in_if  req_if ();
    ps2q_out_if rsp_if ();

    ps2_rx_queue_tx_handshake i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    ps2q_status_checker status_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_popped     (popped),
        .o_overruns   (overruns),
        .o_expiries   (expiries)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("timeout: run did not finish");
        $display("testbench NOT OK");
        $finish;
    end

    // Response side: random back-pressure, plus one long hold-off on request.
    initial begin
        int n;
        hold_served = 1'b0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rsp && !hold_served) begin
                hold_served = 1'b1;
                rsp_if.ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    @(posedge i_clk);
                end
            end
            rsp_if.ready <= no_idle || ($urandom_range(99) >= 33);
        end
    end

    function automatic logic [2:0] pick_mode(input t_bias bias);
        logic [47:0] cuts;
        int          roll;
        // cumulative cutoffs: rx, pop, send, tick, tx done, read errors; rest no-op
        case (bias)
            FILL_QUEUE:  cuts = {8'd70, 8'd80, 8'd85, 8'd92, 8'd96, 8'd98};
            DRAIN_QUEUE: cuts = {8'd25, 8'd75, 8'd82, 8'd88, 8'd92, 8'd97};
            TX_TRAFFIC:  cuts = {8'd15, 8'd25, 8'd45, 8'd80, 8'd90, 8'd96};
            default:     cuts = {8'd35, 8'd60, 8'd70, 8'd82, 8'd88, 8'd95};
        endcase
        roll = $urandom_range(99);
        if (roll < cuts[47:40]) return MODE_RX;
        if (roll < cuts[39:32]) return MODE_POP;
        if (roll < cuts[31:24]) return MODE_SEND;
        if (roll < cuts[23:16]) return MODE_TICK;
        if (roll < cuts[15:8]) return MODE_TX_DONE;
        if (roll < cuts[7:0]) return MODE_READ_ERR;
        return $urandom_range(1) ? MODE_NOP_A : MODE_NOP_B;
    endfunction

    function automatic t_in_item random_request(input t_bias bias);
        t_in_item item;
        item.mode = pick_mode(bias);
        item.data_byte = 8'($urandom_range(255));
        item.parity_bit = 1'($urandom_range(1));
        item.frame_error = 1'($urandom_range(1));
        item.tx_nack = 1'($urandom_range(1));
        if (item.mode == MODE_RX) begin
            // mostly clean frames so the queue actually fills
            item.frame_error = ($urandom_range(11) == 0);
            item.parity_bit = (~^item.data_byte) ^ ($urandom_range(9) == 0);
        end
        return item;
    endfunction

    task automatic issue_request(input t_in_item item);
        while (!no_idle && $urandom_range(99) < 33) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= item;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        requests_issued++;
    endtask

    task automatic issue(input logic [2:0] mode, input logic [7:0] data,
                         input logic par, input logic ferr, input logic nack);
        t_in_item item;
        item.mode = mode;
        item.data_byte = data;
        item.parity_bit = par;
        item.frame_error = ferr;
        item.tx_nack = nack;
        issue_request(item);
    endtask

    task automatic go_quiet();
        int waited;
        waited = 0;
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int                 p;
        int                 k;
        logic [TICKS_W-1:0] ticks;
        t_bias              bias;
        requests_issued = 0;
        req_if.valid <= 1'b0;
        req_if.payload <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        no_idle <= 1'b0;
        hold_rsp <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: corner cases at the reset timeout
        issue(MODE_POP, 8'h00, 1'b0, 1'b0, 1'b0);
        issue(MODE_READ_ERR, 8'hFF, 1'b1, 1'b1, 1'b1);
        issue(MODE_RX, 8'h00, 1'b1, 1'b0, 1'b0);
        issue(MODE_RX, 8'hFF, 1'b1, 1'b0, 1'b1);
        issue(MODE_RX, 8'h80, 1'b0, 1'b0, 1'b0);
        issue(MODE_RX, 8'hA5, 1'b0, 1'b0, 1'b0);
        issue(MODE_RX, 8'h5A, 1'b1, 1'b1, 1'b0);
        issue(MODE_READ_ERR, 8'h00, 1'b0, 1'b0, 1'b0);
        issue(MODE_POP, 8'hFF, 1'b1, 1'b1, 1'b1);
        issue(MODE_POP, 8'h00, 1'b0, 1'b0, 1'b0);
        issue(MODE_POP, 8'h00, 1'b0, 1'b0, 1'b0);
        issue(MODE_POP, 8'h00, 1'b0, 1'b0, 1'b0);
        issue(MODE_SEND, 8'h7F, 1'b0, 1'b0, 1'b0);
        issue(MODE_SEND, 8'h00, 1'b0, 1'b0, 1'b0);
        issue(MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
        issue(MODE_TX_DONE, 8'h00, 1'b0, 1'b0, 1'b1);
        issue(MODE_TX_DONE, 8'h00, 1'b0, 1'b0, 1'b0);
        issue(MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0);
        issue(MODE_SEND, 8'h3C, 1'b0, 1'b0, 1'b0);
        issue(MODE_TX_DONE, 8'h00, 1'b0, 1'b0, 1'b0);
        issue(MODE_NOP_A, 8'hC3, 1'b1, 1'b0, 1'b1);
        issue(MODE_NOP_B, 8'h3C, 1'b0, 1'b1, 1'b0);
        issue(MODE_READ_ERR, 8'h00, 1'b0, 1'b0, 1'b0);

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin ticks = TICKS_W'(1); bias = FILL_QUEUE; end
                1: begin ticks = '0; bias = DRAIN_QUEUE; end
                2: begin ticks = TICKS_W'(3); bias = TX_TRAFFIC; end
                3: begin ticks = '1; bias = MIX_TRAFFIC; end
                4: begin ticks = TICKS_W'($urandom_range(2, 9)); bias = FILL_QUEUE; end
                default: begin ticks = TICKS_W'(2); bias = TX_TRAFFIC; end
            endcase
            go_quiet();
            cfg_wdata <= ticks;
            cfg_we <= 1'b1;
            @(posedge i_clk);
            cfg_we <= 1'b0;
            no_idle <= (p == 2);
            if (p == 0) begin
                hold_rsp <= 1'b1;
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                issue_request(random_request(bias));
            end
        end
        go_quiet();

        $display("%0d requests over %0d timeout settings, %0d responses checked",
                 requests_issued, NUM_PHASES + 1, checked);
        $display("bytes popped %0d, overrun drops %0d, send timeouts %0d",
                 popped, overruns, expiries);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
